>>> design/uart_bt_pkg.sv
// ----------------------------------------------------------------------------
// UART bit transceiver package
// Shared widths, mode and register codes, and the bit-period phase step used
// by both the receiver and the transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_bt_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int PERIOD_W = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Default number of data bits per character
  localparam int DATA_BITS = 8;

  // Register reset values
  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = PERIOD_W'(32);

  // Register indexes (word address within the configuration space)
  localparam logic REG_ENABLE     = 1'b0;
  localparam logic REG_BIT_PERIOD = 1'b1;

  // Machine modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;
  localparam logic [1:0] MODE_DONE = 2'd3;

  // Configuration seen by the datapath
  typedef struct packed {
    logic                enable;
    logic [PERIOD_W-1:0] bit_period;
  } cfg_t;

  // Result of one receiver step
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              stop_err;
  } rx_res_t;

  // Result of one phase counter step
  typedef struct packed {
    logic                tick;
    logic [PERIOD_W-1:0] phase;
  } phase_step_t;

  // Advance a phase counter; a tick marks a bit-period boundary. A period of
  // zero behaves as a period of one.
  function automatic phase_step_t phase_advance(input logic [PERIOD_W-1:0] phase,
                                                input logic [PERIOD_W-1:0] period);
    phase_step_t         res;
    logic [PERIOD_W-1:0] inc;
    inc = PERIOD_W'(phase + 1'b1);
    if ((inc >= period) || (inc == '0)) begin
      res.tick  = 1'b1;
      res.phase = '0;
    end else begin
      res.tick  = 1'b0;
      res.phase = inc;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/uart_bt_in_if.sv
// ----------------------------------------------------------------------------
// UART bit transceiver input channel
// One sampling tick: incoming line level and an optional byte to send.
// ----------------------------------------------------------------------------
`default_nettype none

interface uart_bt_in_if;

  logic                           valid;
  logic                           ready;
  logic                           line_from_design;
  logic                           send_valid;
  logic [uart_bt_pkg::BYTE_W-1:0] send_byte;

  modport source (output valid, output line_from_design, output send_valid,
                  output send_byte, input ready);
  modport sink   (input valid, input line_from_design, input send_valid,
                  input send_byte, output ready);

endinterface

`default_nettype wire

>>> design/uart_bt_out_if.sv
// ----------------------------------------------------------------------------
// UART bit transceiver result channel
// Outgoing line level, received byte status and send acknowledgement.
// ----------------------------------------------------------------------------
`default_nettype none

interface uart_bt_out_if;

  logic                           valid;
  logic                           ready;
  logic                           line_to_design;
  logic                           received_valid;
  logic [uart_bt_pkg::BYTE_W-1:0] received_byte;
  logic                           stop_error;
  logic                           send_taken;

  modport source (output valid, output line_to_design, output received_valid,
                  output received_byte, output stop_error, output send_taken,
                  input ready);
  modport sink   (input valid, input line_to_design, input received_valid,
                  input received_byte, input stop_error, input send_taken,
                  output ready);

endinterface

`default_nettype wire

>>> design/uart_bt_cfg.sv
// ----------------------------------------------------------------------------
// UART bit transceiver configuration registers
// APB-style register file holding the enable bit and the bit period.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_bt_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [uart_bt_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [uart_bt_pkg::DATA_W-1:0]   cfg_pwdata,
  output      logic [uart_bt_pkg::DATA_W-1:0]   cfg_prdata,
  output      logic                             cfg_pready,
  output      uart_bt_pkg::cfg_t                cfg
);

  logic                                enable_r;
  logic                                enable_nxt;
  logic [uart_bt_pkg::PERIOD_W-1:0]    bit_period_r;
  logic [uart_bt_pkg::PERIOD_W-1:0]    bit_period_nxt;
  logic                                wr_en;
  logic                                reg_sel;

  // Word select; byte lanes within a word are not decoded.
  assign reg_sel    = cfg_paddr[2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Register write decode
  always_comb begin
    enable_nxt     = enable_r;
    bit_period_nxt = bit_period_r;
    if (wr_en) begin
      unique case (reg_sel)
        uart_bt_pkg::REG_ENABLE: begin
          enable_nxt = cfg_pwdata[0];
        end
        uart_bt_pkg::REG_BIT_PERIOD: begin
          bit_period_nxt = cfg_pwdata[uart_bt_pkg::PERIOD_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      bit_period_r <= uart_bt_pkg::BIT_PERIOD_RESET;
    end else begin
      enable_r     <= enable_nxt;
      bit_period_r <= bit_period_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      uart_bt_pkg::REG_ENABLE: begin
        cfg_prdata = uart_bt_pkg::DATA_W'(enable_r);
      end
      uart_bt_pkg::REG_BIT_PERIOD: begin
        cfg_prdata = uart_bt_pkg::DATA_W'(bit_period_r);
      end
    endcase
  end

  assign cfg.enable     = enable_r;
  assign cfg.bit_period = bit_period_r;

endmodule

`default_nettype wire

>>> design/uart_bt_rx.sv
// ----------------------------------------------------------------------------
// UART bit transceiver receiver
// Detects a start level, samples the data bits LSB first once per bit period
// and reports the character together with the sampled stop level.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_bt_rx #(
  parameter int DATA_BITS = uart_bt_pkg::DATA_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [uart_bt_pkg::PERIOD_W-1:0] bit_period,
  input  wire logic                             line_in,
  output      uart_bt_pkg::rx_res_t             res
);

  localparam int CNT_W  = $clog2(DATA_BITS + 1);
  localparam int KEEP_W = (DATA_BITS < uart_bt_pkg::BYTE_W) ? DATA_BITS
                                                            : uart_bt_pkg::BYTE_W;

  logic [1:0]                       mode_r,  mode_nxt;
  logic [DATA_BITS-1:0]             shift_r, shift_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [uart_bt_pkg::PERIOD_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]                 count_inc;
  uart_bt_pkg::phase_step_t         pstep;
  logic                             done;

  assign pstep     = uart_bt_pkg::phase_advance(phase_r, bit_period);
  assign count_inc = CNT_W'(count_r + 1'b1);

  // Next state for one tick
  always_comb begin
    mode_nxt  = mode_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    done      = 1'b0;
    if (step) begin
      if ((mode_r == uart_bt_pkg::MODE_DATA) || (mode_r == uart_bt_pkg::MODE_STOP)) begin
        phase_nxt = pstep.phase;
        if (pstep.tick) begin
          if (mode_r == uart_bt_pkg::MODE_DATA) begin
            shift_nxt = {line_in, shift_r[DATA_BITS-1:1]};
            count_nxt = count_inc;
            if (count_inc >= CNT_W'(DATA_BITS)) begin
              mode_nxt = uart_bt_pkg::MODE_STOP;
            end
          end else begin
            done      = 1'b1;
            mode_nxt  = uart_bt_pkg::MODE_IDLE;
            shift_nxt = '0;
            count_nxt = '0;
            phase_nxt = '0;
          end
        end
      end else begin
        mode_nxt = uart_bt_pkg::MODE_IDLE;
        if (!line_in) begin
          mode_nxt  = uart_bt_pkg::MODE_DATA;
          phase_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= uart_bt_pkg::MODE_IDLE;
      shift_r <= '0;
      count_r <= '0;
      phase_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

  // A character wider than a byte keeps only its first eight bits here.
  assign res.valid    = done;
  assign res.data     = done ? uart_bt_pkg::BYTE_W'(shift_r[KEEP_W-1:0]) : '0;
  assign res.stop_err = done & ~line_in;

endmodule

`default_nettype wire

>>> design/uart_bt_tx.sv
// ----------------------------------------------------------------------------
// UART bit transceiver transmitter
// Takes an offered byte while idle and drives start, data, stop and one
// trailing idle period on the outgoing line.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_bt_tx #(
  parameter int DATA_BITS = uart_bt_pkg::DATA_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [uart_bt_pkg::PERIOD_W-1:0] bit_period,
  input  wire logic                             offer,
  input  wire logic [uart_bt_pkg::BYTE_W-1:0]   byte_in,
  output      logic                             taken,
  output      logic                             line_nxt
);

  localparam int CNT_W = $clog2(DATA_BITS + 1);

  logic [1:0]                       mode_r,  mode_nxt;
  logic [uart_bt_pkg::BYTE_W-1:0]   shift_r, shift_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [uart_bt_pkg::PERIOD_W-1:0] phase_r, phase_nxt;
  logic                             line_r;
  logic [CNT_W-1:0]                 count_inc;
  uart_bt_pkg::phase_step_t         pstep;

  assign pstep     = uart_bt_pkg::phase_advance(phase_r, bit_period);
  assign count_inc = CNT_W'(count_r + 1'b1);

  // Next state for one tick; a ninth data bit shifts out as zero.
  always_comb begin
    mode_nxt  = mode_r;
    shift_nxt = shift_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    line_nxt  = line_r;
    taken     = 1'b0;
    if (step) begin
      if (mode_r == uart_bt_pkg::MODE_IDLE) begin
        if (offer) begin
          taken     = 1'b1;
          shift_nxt = byte_in;
          count_nxt = '0;
          line_nxt  = 1'b0;
          mode_nxt  = uart_bt_pkg::MODE_DATA;
          phase_nxt = '0;
        end
      end else begin
        phase_nxt = pstep.phase;
        if (pstep.tick) begin
          unique case (mode_r)
            uart_bt_pkg::MODE_DATA: begin
              line_nxt  = shift_r[0];
              shift_nxt = shift_r >> 1;
              count_nxt = count_inc;
              if (count_inc >= CNT_W'(DATA_BITS)) begin
                mode_nxt = uart_bt_pkg::MODE_STOP;
              end
            end
            uart_bt_pkg::MODE_STOP: begin
              line_nxt = 1'b1;
              mode_nxt = uart_bt_pkg::MODE_DONE;
            end
            default: begin
              mode_nxt  = uart_bt_pkg::MODE_IDLE;
              shift_nxt = '0;
              count_nxt = '0;
              phase_nxt = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= uart_bt_pkg::MODE_IDLE;
      shift_r <= '0;
      count_r <= '0;
      phase_r <= '0;
      line_r  <= 1'b1;
    end else begin
      mode_r  <= mode_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/uart_bit_transceiver_unit.sv
// ----------------------------------------------------------------------------
// UART bit transceiver unit
// An 8N1-style serial receiver and transmitter driven one sampling tick at a
// time.
//
// Each transfer on in_chan is one sampling tick: the incoming line level and
// an optional byte offered for sending. Each tick produces exactly one
// transfer on out_chan with the outgoing line level, a received byte when a
// character completes on that tick, its stop-level error flag, and whether
// the offered byte was taken. When the enable register is clear the state
// holds and the result carries only the held line level.
// A tick is captured in an input register and worked through the receiver
// and transmitter into the result register; one tick is accepted every
// cycle while out_chan keeps taking results.
// When out_chan stalls, the result register holds its transfer and the
// input register holds one more tick; in_chan drops ready only when both are
// full. Configuration writes on the cfg_ port are expected while no tick is
// in flight. The synchronous reset clears the valid flags of both pipeline
// registers, returns both machines to idle with the outgoing line high,
// clears enable and sets the bit period to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_bit_transceiver_unit #(
  parameter int DATA_BITS = uart_bt_pkg::DATA_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  uart_bt_in_if.sink                            in_chan,
  uart_bt_out_if.source                         out_chan,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [uart_bt_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire logic [uart_bt_pkg::DATA_W-1:0]   cfg_pwdata,
  output      logic [uart_bt_pkg::DATA_W-1:0]   cfg_prdata,
  output      logic                             cfg_pready
);

  uart_bt_pkg::cfg_t                cfg;
  uart_bt_pkg::rx_res_t             rx_res;

  logic                             s1_valid_r, s1_valid_nxt;
  logic                             s1_line_r;
  logic                             s1_offer_r;
  logic [uart_bt_pkg::BYTE_W-1:0]   s1_byte_r;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_line_r;
  logic                             out_rx_valid_r;
  logic [uart_bt_pkg::BYTE_W-1:0]   out_rx_byte_r;
  logic                             out_stop_err_r;
  logic                             out_taken_r;

  logic                             in_fire;
  logic                             out_load;
  logic                             step;
  logic                             tx_taken;
  logic                             tx_line_nxt;

  // Configuration registers
  uart_bt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Pipeline flow control
  assign out_load      = ~out_valid_r | out_chan.ready;
  assign in_chan.ready = ~s1_valid_r | out_load;
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign step          = s1_valid_r & out_load & cfg.enable;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_line_r  <= in_chan.line_from_design;
      s1_offer_r <= in_chan.send_valid;
      s1_byte_r  <= in_chan.send_byte;
    end
  end

  // Receiver and transmitter
  uart_bt_rx #(
    .DATA_BITS (DATA_BITS)
  ) u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .bit_period (cfg.bit_period),
    .line_in    (s1_line_r),
    .res        (rx_res)
  );

  uart_bt_tx #(
    .DATA_BITS (DATA_BITS)
  ) u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .bit_period (cfg.bit_period),
    .offer      (s1_offer_r),
    .byte_in    (s1_byte_r),
    .taken      (tx_taken),
    .line_nxt   (tx_line_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_line_r     <= tx_line_nxt;
      out_rx_valid_r <= rx_res.valid;
      out_rx_byte_r  <= rx_res.data;
      out_stop_err_r <= rx_res.stop_err;
      out_taken_r    <= tx_taken;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.line_to_design = out_line_r;
  assign out_chan.received_valid = out_rx_valid_r;
  assign out_chan.received_byte  = out_rx_byte_r;
  assign out_chan.stop_error     = out_stop_err_r;
  assign out_chan.send_taken     = out_taken_r;

endmodule

`default_nettype wire

>>> verif/tb_uart_bit_transceiver_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the UART bit transceiver unit
// Drives sampling ticks into the block and mirrors the receiver and the
// transmitter in a tick-accurate model of its own. Every result transfer is
// checked field by field against the model. Directed tests cover the idle
// block, a zero bit period, offers while busy and the longest bit period.
// A back-pressure test fills the pipeline. Random traffic then sends mostly
// well-formed serial frames with random content, plus noise and broken
// frames, over several bit periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_uart_bit_transceiver_unit;

  // Byte addresses of the configuration registers
  localparam logic [uart_bt_pkg::ADDR_W-1:0] ADDR_ENABLE =
    {uart_bt_pkg::REG_ENABLE, 2'b00};
  localparam logic [uart_bt_pkg::ADDR_W-1:0] ADDR_BIT_PERIOD =
    {uart_bt_pkg::REG_BIT_PERIOD, 2'b00};

  localparam int HOLD_OFF_CYCLES = 60;
  localparam int LONGEST_PERIOD  = 255;

  // One sampling tick as offered on the input channel
  typedef struct packed {
    logic                           line;
    logic                           send_valid;
    logic [uart_bt_pkg::BYTE_W-1:0] send_byte;
  } tick_t;

  // One result as carried by the result channel
  typedef struct packed {
    logic                           line;
    logic                           rx_valid;
    logic [uart_bt_pkg::BYTE_W-1:0] rx_byte;
    logic                           stop_err;
    logic                           taken;
  } line_result_t;

  logic clk;
  logic rst_n;

  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [uart_bt_pkg::ADDR_W-1:0] cfg_paddr;
  logic [uart_bt_pkg::DATA_W-1:0] cfg_pwdata;
  logic [uart_bt_pkg::DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  uart_bt_in_if  in_if ();
  uart_bt_out_if out_if ();

  uart_bit_transceiver_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock: 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mirrored configuration and machine state
  logic                             mdl_enable = 1'b0;
  logic [uart_bt_pkg::PERIOD_W-1:0] mdl_period = uart_bt_pkg::BIT_PERIOD_RESET;
  logic [1:0]                       rx_mode    = uart_bt_pkg::MODE_IDLE;
  logic [uart_bt_pkg::BYTE_W-1:0]   rx_shift   = '0;
  logic [3:0]                       rx_count   = '0;
  logic [uart_bt_pkg::PERIOD_W-1:0] rx_phase   = '0;
  logic [1:0]                       tx_mode    = uart_bt_pkg::MODE_IDLE;
  logic [uart_bt_pkg::BYTE_W-1:0]   tx_shift   = '0;
  logic [3:0]                       tx_count   = '0;
  logic [uart_bt_pkg::PERIOD_W-1:0] tx_phase   = '0;
  logic                             tx_line    = 1'b1;

  line_result_t results_due[$];
  int           error_count = 0;
  int           ticks_sent  = 0;
  int           offer_odds  = 4;
  bit           steady      = 1'b0;
  bit           hold_off_req = 1'b0;

  // Advance a phase counter; true at a bit-period boundary. A zero period
  // acts as a period of one.
  function automatic logic bump_phase(inout logic [uart_bt_pkg::PERIOD_W-1:0] ph);
    ph = ph + 1'b1;
    if ((ph >= mdl_period) || (ph == '0)) begin
      ph = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work one tick through the mirrored receiver and transmitter.
  function automatic line_result_t step_uart(input tick_t t);
    line_result_t r;
    r = '0;
    if (mdl_enable) begin
      // Receiver: hunt for a start level, then sample once per bit period
      if ((rx_mode == uart_bt_pkg::MODE_DATA) || (rx_mode == uart_bt_pkg::MODE_STOP)) begin
        if (bump_phase(rx_phase)) begin
          if (rx_mode == uart_bt_pkg::MODE_DATA) begin
            rx_shift = {t.line, rx_shift[uart_bt_pkg::BYTE_W-1:1]};
            rx_count = rx_count + 4'd1;
            if (rx_count >= uart_bt_pkg::DATA_BITS) rx_mode = uart_bt_pkg::MODE_STOP;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_shift;
            r.stop_err = ~t.line;
            rx_mode    = uart_bt_pkg::MODE_IDLE;
            rx_shift   = '0;
            rx_count   = '0;
            rx_phase   = '0;
          end
        end
      end else if (!t.line) begin
        rx_mode  = uart_bt_pkg::MODE_DATA;
        rx_phase = '0;
      end else begin
        rx_mode = uart_bt_pkg::MODE_IDLE;
      end

      // Transmitter: start bit on take, then data, stop and one spare period
      if (tx_mode == uart_bt_pkg::MODE_IDLE) begin
        if (t.send_valid) begin
          r.taken  = 1'b1;
          tx_shift = t.send_byte;
          tx_count = '0;
          tx_line  = 1'b0;
          tx_mode  = uart_bt_pkg::MODE_DATA;
          tx_phase = '0;
        end
      end else if (bump_phase(tx_phase)) begin
        case (tx_mode)
          uart_bt_pkg::MODE_DATA: begin
            tx_line  = tx_shift[0];
            tx_shift = tx_shift >> 1;
            tx_count = tx_count + 4'd1;
            if (tx_count >= uart_bt_pkg::DATA_BITS) tx_mode = uart_bt_pkg::MODE_STOP;
          end
          uart_bt_pkg::MODE_STOP: begin
            tx_line = 1'b1;
            tx_mode = uart_bt_pkg::MODE_DONE;
          end
          default: begin
            tx_mode  = uart_bt_pkg::MODE_IDLE;
            tx_shift = '0;
            tx_count = '0;
            tx_phase = '0;
          end
        endcase
      end
    end
    r.line = tx_line;
    return r;
  endfunction

  function automatic int eff_period();
    return (mdl_period == '0) ? 1 : int'(mdl_period);
  endfunction

  // Offer one tick and wait for its transfer; entered and left at a falling edge.
  task automatic send_tick(input tick_t t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.line_from_design <= t.line;
    in_if.send_valid       <= t.send_valid;
    in_if.send_byte        <= t.send_byte;
    do @(posedge clk); while (!in_if.ready);
    results_due.push_back(step_uart(t));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Hold the incoming line at one level for a number of ticks, with random offers.
  task automatic send_line(input logic level, input int n);
    tick_t t;
    repeat (n) begin
      t.line       = level;
      t.send_valid = (offer_odds != 0) && ($urandom_range(0, offer_odds - 1) == 0);
      t.send_byte  = uart_bt_pkg::BYTE_W'($urandom);
      send_tick(t);
    end
  endtask

  // One serial frame on the incoming line: start, eight data bits, stop.
  task automatic send_frame(input logic [uart_bt_pkg::BYTE_W-1:0] b,
                            input logic stop_level);
    int p;
    p = eff_period();
    send_line(1'b0, p);
    for (int i = 0; i < uart_bt_pkg::DATA_BITS; i++) send_line(b[i], p);
    send_line(stop_level, p);
    // A low stop level reads as a new start; let the receiver run it out.
    if (!stop_level) send_line(1'b1, (p > 1) ? 11 * p : 1);
  endtask

  // Stop offering and wait until the pipeline is empty.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write followed by a read-back; entered and left at a falling edge.
  task automatic write_reg(input logic [uart_bt_pkg::ADDR_W-1:0] addr,
                           input logic [uart_bt_pkg::DATA_W-1:0] data,
                           input logic [uart_bt_pkg::DATA_W-1:0] readback);
    logic [uart_bt_pkg::DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_ENABLE) mdl_enable = data[0];
    else mdl_period = data[uart_bt_pkg::PERIOD_W-1:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== readback) begin
      $error("register read-back at 0x%0h: expected 0x%0h, got 0x%0h", addr, readback, got);
      error_count++;
    end
  endtask

  task automatic set_enable(input logic v);
    logic [uart_bt_pkg::DATA_W-1:0] d;
    d    = $urandom;
    d[0] = v;
    write_reg(ADDR_ENABLE, d, uart_bt_pkg::DATA_W'(v));
  endtask

  task automatic set_period(input int p);
    logic [uart_bt_pkg::DATA_W-1:0] d;
    d                             = $urandom;
    d[uart_bt_pkg::PERIOD_W-1:0]  = p[uart_bt_pkg::PERIOD_W-1:0];
    write_reg(ADDR_BIT_PERIOD, d, uart_bt_pkg::DATA_W'(p[uart_bt_pkg::PERIOD_W-1:0]));
  endtask

  // Compare one result field.
  task automatic check_field(input string name, input logic [uart_bt_pkg::BYTE_W-1:0] want_v,
                             input logic [uart_bt_pkg::BYTE_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endtask

  // Result checker: every result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with no tick outstanding");
        error_count++;
      end else begin
        want = results_due.pop_front();
        check_field("line_to_design", uart_bt_pkg::BYTE_W'(want.line),
                    uart_bt_pkg::BYTE_W'(out_if.line_to_design));
        check_field("received_valid", uart_bt_pkg::BYTE_W'(want.rx_valid),
                    uart_bt_pkg::BYTE_W'(out_if.received_valid));
        check_field("received_byte", want.rx_byte, out_if.received_byte);
        check_field("stop_error", uart_bt_pkg::BYTE_W'(want.stop_err),
                    uart_bt_pkg::BYTE_W'(out_if.stop_error));
        check_field("send_taken", uart_bt_pkg::BYTE_W'(want.taken),
                    uart_bt_pkg::BYTE_W'(out_if.send_taken));
      end
    end
  end

  // Result receiver: random stalls per transfer, and a long hold-off on request
  initial begin : result_drain
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  // The block out of reset is disabled: only the idle line level comes back.
  task automatic test_disabled();
    send_tick('{line: 1'b0, send_valid: 1'b1, send_byte: 8'hFF});
    send_tick('{line: 1'b1, send_valid: 1'b1, send_byte: 8'h00});
    send_tick('{line: 1'b0, send_valid: 1'b0, send_byte: 8'hAA});
    send_tick('{line: 1'b1, send_valid: 1'b0, send_byte: 8'h55});
    wait_drained();
  endtask

  // Zero bit period, all-ones and all-zeros bytes, a low stop level and
  // offers while the transmitter is busy.
  task automatic test_zero_period();
    set_period(0);
    set_enable(1'b1);
    offer_odds = 0;
    send_tick('{line: 1'b1, send_valid: 1'b1, send_byte: 8'h00});
    offer_odds = 2;
    send_frame(8'hFF, 1'b1);
    send_tick('{line: 1'b1, send_valid: 1'b1, send_byte: 8'hFF});
    send_frame(8'h00, 1'b0);
    offer_odds = 4;
    wait_drained();
  endtask

  // The receiver stops taking results while the sender keeps offering ticks.
  task automatic test_output_stall();
    set_period(2);
    steady       = 1'b1;
    hold_off_req = 1'b1;
    send_frame(uart_bt_pkg::BYTE_W'($urandom), 1'b1);
    send_line(1'b1, 4);
    wait_drained();
    steady = 1'b0;
  endtask

  // The first bit boundary each way at the longest bit period: a start bit
  // held for a whole period on the line while a byte goes out.
  task automatic test_longest_period();
    set_period(LONGEST_PERIOD);
    offer_odds = 0;
    send_tick('{line: 1'b1, send_valid: 1'b1, send_byte: 8'($urandom)});
    send_line(1'b0, LONGEST_PERIOD);
    send_line(1'b1, 4);
    offer_odds = 4;
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames.
  task automatic test_random_traffic();
    int start;
    int p;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_period(1);
        3:       set_period($urandom_range(7, 10));
        default: set_period($urandom_range(1, 6));
      endcase
      set_enable(1'b1);
      steady     = (ph == 1) || (ph == 3);
      offer_odds = $urandom_range(1, 6);
      start      = ticks_sent;
      p          = eff_period();
      // Disable mid-frame: the machines must hold where they are.
      if (ph == 2) begin
        send_line(1'b0, p);
        send_line(1'($urandom_range(0, 1)), 3 * p);
        wait_drained();
        set_enable(1'b0);
        send_line(1'($urandom_range(0, 1)), 12);
        wait_drained();
        set_enable(1'b1);
        start = ticks_sent;
      end
      while (ticks_sent - start < 40) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 6)) begin
              send_line(1'($urandom_range(0, 1)), $urandom_range(1, 3));
            end
          end
          1: begin
            send_line(1'b0, p);
            repeat ($urandom_range(1, 7)) send_line(1'($urandom_range(0, 1)), p);
            send_line(1'b1, 11 * p);
          end
          default: begin
            send_frame(uart_bt_pkg::BYTE_W'($urandom), ($urandom_range(0, 7) != 0));
            send_line(1'b1, $urandom_range(0, 3));
          end
        endcase
      end
      wait_drained();
    end
    steady = 1'b0;
  endtask

  // Sequence of tests
  initial begin : main_sequence
    int guard;
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.line_from_design = 1'b1;
    in_if.send_valid       = 1'b0;
    in_if.send_byte        = '0;
    cfg_psel               = 1'b0;
    cfg_penable            = 1'b0;
    cfg_pwrite             = 1'b0;
    cfg_paddr              = '0;
    cfg_pwdata             = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_disabled();
    test_zero_period();
    test_output_stall();
    test_longest_period();
    test_random_traffic();

    in_if.valid <= 1'b0;
    guard = 0;
    while ((results_due.size() != 0) && (guard < 5000)) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_uart_bit_transceiver_unit: done, clean");
    end else begin
      $display("tb_uart_bit_transceiver_unit: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("tb_uart_bit_transceiver_unit: done, errors");
    $finish;
  end

endmodule
